### rtl/fxalu_pkg.sv
// Shared types, action codes and widths for the Q24.8 fixed-point ALU.
// No dependencies; used by every file of the block.
package fxalu_pkg;

    localparam int DW = 32;
    localparam int FB = 8;
    localparam int MW = DW;              // magnitude width
    localparam int NW = DW + FB;         // dividend width (magnitude << FB)
    localparam int CW = MW + 1;          // remainder width in a divider cell

    localparam logic [3:0] ACT_ADD  = 4'd0;
    localparam logic [3:0] ACT_SUB  = 4'd1;
    localparam logic [3:0] ACT_MUL  = 4'd2;
    localparam logic [3:0] ACT_DIV  = 4'd3;
    localparam logic [3:0] ACT_MIN  = 4'd4;
    localparam logic [3:0] ACT_MAX  = 4'd5;
    localparam logic [3:0] ACT_INC  = 4'd6;
    localparam logic [3:0] ACT_DEC  = 4'd7;
    localparam logic [3:0] ACT_I2F  = 4'd8;
    localparam logic [3:0] ACT_F2I  = 4'd9;

    // Word travelling down the divider chain
    typedef struct packed {
        logic          valid;
        logic [CW-1:0] rem;
        logic [NW-1:0] num;     // dividend bits shift out, quotient bits shift in
        logic [MW-1:0] den;
        logic          neg;
        logic          dbz;
        logic          is_div;
        logic [DW-1:0] res;     // finished result of non-divide actions
        logic          ovf;
        logic [2:0]    cmp;     // less, equal, greater
    } fxalu_word_t;

    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

endpackage

### rtl/fxalu_cell.sv
// One restoring-division cell: takes one quotient bit and passes the word on.
// Depends on fxalu_pkg.
module fxalu_cell import fxalu_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  fxalu_word_t din,
    output fxalu_word_t dout
);
    fxalu_word_t word_reg, word_next;
    logic [CW-1:0] shifted;
    logic [CW:0]   diff;

    // Shift one dividend bit into the remainder and try a subtract
    always_comb
    begin
        word_next = din;
        shifted   = {din.rem[CW-2:0], din.num[NW-1]};
        diff      = {1'b0, shifted} - {2'b00, din.den};
        if (diff[CW])
        begin
            word_next.rem = shifted;
            word_next.num = {din.num[NW-2:0], 1'b0};
        end
        else
        begin
            word_next.rem = diff[CW-1:0];
            word_next.num = {din.num[NW-2:0], 1'b1};
        end
    end

    // Hold the word for the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_next;
    end

    assign dout = word_reg;
endmodule

### rtl/fxalu_front.sv
// Front stage: decodes the action, does all non-divide arithmetic and loads
// the divider word. Depends on fxalu_pkg.
module fxalu_front import fxalu_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [3:0]        action,
    input  logic signed [DW-1:0] operand_a,
    input  logic signed [DW-1:0] operand_b,
    output fxalu_word_t       dout
);
    // Stage 1 registers: product and operands
    logic          v1_reg;
    logic [3:0]    act1_reg;
    logic [DW-1:0] a1_reg, b1_reg;
    logic [2*MW-1:0] prod1_reg;
    logic [MW-1:0] ma, mb;
    fxalu_word_t   word_reg, word_next;

    assign ma = operand_a[DW-1] ? (~operand_a + 1'b1) : operand_a;
    assign mb = operand_b[DW-1] ? (~operand_b + 1'b1) : operand_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    // Register operands and the magnitude product
    always_ff @(posedge clk)
    begin
        act1_reg  <= action;
        a1_reg    <= operand_a;
        b1_reg    <= operand_b;
        prod1_reg <= ma * mb;
    end

    logic [MW-1:0] m1a, m1b;
    logic          neg1;
    logic [DW:0]   sum, dif;
    logic [2*MW-1:0] prnd;
    logic [2*MW-FB-1:0] pmag;
    logic [MW+FB-1:0]   imag;
    logic          lt, eq;

    // Finish every action but divide
    always_comb
    begin
        m1a  = a1_reg[DW-1] ? (~a1_reg + 1'b1) : a1_reg;
        m1b  = b1_reg[DW-1] ? (~b1_reg + 1'b1) : b1_reg;
        neg1 = a1_reg[DW-1] ^ b1_reg[DW-1];
        sum  = {a1_reg[DW-1], a1_reg} + {b1_reg[DW-1], b1_reg};
        dif  = {a1_reg[DW-1], a1_reg} - {b1_reg[DW-1], b1_reg};
        prnd = prod1_reg + {{(2*MW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
        pmag = prnd[2*MW-1:FB];
        imag = {m1a, {FB{1'b0}}};
        lt   = $signed(a1_reg) < $signed(b1_reg);
        eq   = a1_reg == b1_reg;

        word_next        = '0;
        word_next.valid  = v1_reg;
        word_next.cmp    = {lt, eq, !lt && !eq};
        word_next.neg    = neg1;
        word_next.den    = m1b;
        word_next.num    = {m1a, {FB{1'b0}}};
        word_next.is_div = act1_reg == ACT_DIV;
        word_next.dbz    = (act1_reg == ACT_DIV) && (b1_reg == '0);
        case (act1_reg)
            ACT_ADD, ACT_SUB:
            begin
                if (act1_reg == ACT_ADD)
                begin
                    word_next.res = sum[DW-1:0];
                    word_next.ovf = sum[DW] != sum[DW-1];
                    if (word_next.ovf)
                        word_next.res = sum[DW] ? SMIN : SMAX;
                end
                else
                begin
                    word_next.res = dif[DW-1:0];
                    word_next.ovf = dif[DW] != dif[DW-1];
                    if (word_next.ovf)
                        word_next.res = dif[DW] ? SMIN : SMAX;
                end
            end
            ACT_MUL:
            begin
                if (neg1)
                begin
                    if (pmag > {{(MW-FB){1'b0}}, SMIN})
                    begin
                        word_next.res = SMIN;
                        word_next.ovf = 1'b1;
                    end
                    else
                        word_next.res = ~pmag[DW-1:0] + 1'b1;
                end
                else if (pmag > {{(MW-FB){1'b0}}, SMAX})
                begin
                    word_next.res = SMAX;
                    word_next.ovf = 1'b1;
                end
                else
                    word_next.res = pmag[DW-1:0];
            end
            ACT_MIN: word_next.res = (lt || eq) ? a1_reg : b1_reg;
            ACT_MAX: word_next.res = (!lt) ? a1_reg : b1_reg;
            ACT_INC: word_next.res = a1_reg + 1'b1;
            ACT_DEC: word_next.res = a1_reg - 1'b1;
            ACT_I2F:
            begin
                if (a1_reg[DW-1])
                begin
                    if (imag > {{FB{1'b0}}, SMIN})
                    begin
                        word_next.res = SMIN;
                        word_next.ovf = 1'b1;
                    end
                    else
                        word_next.res = ~imag[DW-1:0] + 1'b1;
                end
                else if (imag > {{FB{1'b0}}, SMAX})
                begin
                    word_next.res = SMAX;
                    word_next.ovf = 1'b1;
                end
                else
                    word_next.res = imag[DW-1:0];
            end
            ACT_F2I: word_next.res = DW'($signed(a1_reg) >>> FB);
            default: word_next.res = '0;
        endcase
        // Divide by zero leaves the divider harmless
        if (word_next.dbz)
            word_next.den = {{(MW-1){1'b0}}, 1'b1};
    end

    // Hold the decoded word for the first divider cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_next;
    end

    assign dout = word_reg;
endmodule

### rtl/fxalu_back.sv
// Back stage: rounds and saturates the quotient, selects the final word and
// drives the result ports. Depends on fxalu_pkg.
module fxalu_back import fxalu_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  fxalu_word_t       din,
    output logic              done,
    output logic signed [DW-1:0] result,
    output logic              less,
    output logic              equal,
    output logic              greater,
    output logic              overflow,
    output logic              divide_by_zero
);
    logic          done_reg;
    logic [DW-1:0] res_reg, res_next;
    logic [2:0]    cmp_reg;
    logic          ovf_reg, ovf_next, dbz_reg;
    logic [CW:0]   twice;
    logic [NW:0]   q;

    // Round the quotient half up, then saturate with sign
    always_comb
    begin
        twice    = {1'b0, din.rem} + {1'b0, din.rem};
        q        = {1'b0, din.num} + {{NW{1'b0}}, (twice >= {2'b00, din.den})};
        res_next = din.res;
        ovf_next = din.ovf;
        if (din.is_div)
        begin
            ovf_next = 1'b0;
            if (din.dbz)
                res_next = '0;
            else if (din.neg)
            begin
                if (q > {{(NW-DW+1){1'b0}}, SMIN})
                begin
                    res_next = SMIN;
                    ovf_next = 1'b1;
                end
                else
                    res_next = ~q[DW-1:0] + 1'b1;
            end
            else if (q > {{(NW-DW+1){1'b0}}, SMAX})
            begin
                res_next = SMAX;
                ovf_next = 1'b1;
            end
            else
                res_next = q[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        ovf_reg <= ovf_next;
        dbz_reg <= din.dbz;
        cmp_reg <= din.cmp;
    end

    assign done           = done_reg;
    assign result         = res_reg;
    assign less           = cmp_reg[2];
    assign equal          = cmp_reg[1];
    assign greater        = cmp_reg[0];
    assign overflow       = ovf_reg;
    assign divide_by_zero = dbz_reg;
endmodule

### rtl/fixed_point_alu_q24_8.sv
// Signed Q24.8 fixed-point ALU: top level, front stage, divider chain, back stage.
// Depends on fxalu_pkg, fxalu_front, fxalu_cell, fxalu_back.
//
// Takes one word per clock (busy is always low) and returns each result on
// the result ports for one cycle with done high. The word passes 43 register
// stages: 2 front stages (operand and product register, then decode), 40
// divider cells (one quotient bit each over the 40-bit dividend), and one
// round/saturate stage that registers done. Every action uses the same
// latency, so results leave in order. The receiver cannot stall; results
// must be taken when shown.
module fixed_point_alu_q24_8 import fxalu_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [3:0]        action,
    input  logic signed [DW-1:0] operand_a,
    input  logic signed [DW-1:0] operand_b,
    output logic              done,
    output logic signed [DW-1:0] result,
    output logic              less,
    output logic              equal,
    output logic              greater,
    output logic              overflow,
    output logic              divide_by_zero
);
    fxalu_word_t chain [NW+1];

    assign busy = 1'b0;

    fxalu_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action),
        .operand_a(operand_a), .operand_b(operand_b), .dout(chain[0])
    );

    // One cell per quotient bit
    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        fxalu_cell u_cell (.clk(clk), .rst_n(rst_n), .din(chain[i]), .dout(chain[i+1]));
    end

    fxalu_back u_back (
        .clk(clk), .rst_n(rst_n), .din(chain[NW]), .done(done), .result(result),
        .less(less), .equal(equal), .greater(greater), .overflow(overflow),
        .divide_by_zero(divide_by_zero)
    );
endmodule

### rtl/fxalu_checker.sv
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fxalu_pkg.
module fxalu_checker import fxalu_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic done,
    input logic less,
    input logic equal,
    input logic greater,
    input logic overflow,
    input logic divide_by_zero
);
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot({less, equal, greater})) else $error("compare flags");
    a_dbz_eq: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_by_zero |-> !overflow) else $error("dbz with overflow");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy) else $error("busy raised");
endmodule

bind fixed_point_alu_q24_8 fxalu_checker u_chk (
    .clk(clk), .rst_n(rst_n), .busy(busy), .done(done), .less(less),
    .equal(equal), .greater(greater), .overflow(overflow),
    .divide_by_zero(divide_by_zero)
);
